// ===== rtl/tcr_pkg.sv =====
package tcr_pkg;

    // Storage geometry
    localparam int RING_DEPTH   = 131072;
    localparam int RING_AW      = $clog2(RING_DEPTH);
    localparam int MAX_SEGMENTS = 16;
    localparam int SEG_AW       = $clog2(MAX_SEGMENTS);
    localparam int SEG_CW       = SEG_AW + 1;

    // Field widths
    localparam int SAMPLE_W = 32;
    localparam int COUNT_W  = 48;
    localparam int POS_W    = 47;
    localparam int GUARD_W  = 17;
    localparam int CHAN_W   = 2;
    localparam int WIN_W    = RING_AW + 1;

    localparam int S_TDATA_W = 160;
    localparam int M_TDATA_W = 72;

    // Item kinds carried in s_tuser
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // Configuration register indexes and reset values
    localparam logic REG_INPUT_CHANNELS = 1'b0;
    localparam logic REG_GUARD_SAMPLES  = 1'b1;
    localparam logic [CHAN_W-1:0]  INPUT_CHANNELS_RST = 2'd2;
    localparam logic [GUARD_W:0]   GUARD_SAMPLES_RST  = 18'd65536;

    // One classified item as it waits in the queue
    typedef struct packed {
        logic                mode;
        logic [SAMPLE_W-1:0] ch0;
        logic [SAMPLE_W-1:0] ch1;
        logic                tl_none;
        logic [POS_W-1:0]    tl;
        logic [POS_W-1:0]    query;
    } item_t;

    // Configuration as seen by the execution side
    typedef struct packed {
        logic               mono;
        logic [WIN_W-1:0]   usable;
    } cfg_t;

    // Handshake between queue and execution side
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage

// ===== rtl/tcr_front.sv =====
module tcr_front import tcr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: sample_ch0, sample_ch1, timeline_pos, query_pos, one pad bit
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: mode
    input  logic                 s_tuser,
    output queue_head_t          head,
    input  logic                 pop
);

    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    item_t       fifo_reg [2];
    item_t       in_item;
    logic        full, empty, push;

    // Classify the incoming transaction: any negative timeline means none.
    always_comb begin
        in_item.mode    = s_tuser;
        in_item.ch0     = s_tdata[31:0];
        in_item.ch1     = s_tdata[63:32];
        in_item.tl_none = s_tdata[111];
        in_item.tl      = s_tdata[110:64];
        in_item.query   = s_tdata[158:112];
    end

    assign full     = (wr_ptr_reg[1] != rd_ptr_reg[1]) && (wr_ptr_reg[0] == rd_ptr_reg[0]);
    assign empty    = (wr_ptr_reg == rd_ptr_reg);
    assign s_tready = !full;
    assign push     = s_tvalid && !full;

    assign head.valid = !empty;
    assign head.item  = fifo_reg[rd_ptr_reg[0]];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = (pop && !empty) ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
    end

    // Queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg[0]] <= in_item;
        end
    end

endmodule

// ===== rtl/tcr_back.sv =====
module tcr_back import tcr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  queue_head_t          head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: out_ch0, out_ch1, covered, overrun, opened_segment, five pad bits
    output logic [M_TDATA_W-1:0] m_tdata
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_WR_CHK = 9'b000000010,
        ST_WR_UPD = 9'b000000100,
        ST_RD_SCN = 9'b000001000,
        ST_RD_POS = 9'b000010000,
        ST_RD_AGE = 9'b000100000,
        ST_RD_DAT = 9'b001000000,
        ST_OUT    = 9'b010000000,
        ST_SPARE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Sample ring memory
    logic [2*SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    logic [2*SAMPLE_W-1:0] rdata_reg;
    logic                  ring_we;

    // Segment table
    logic [COUNT_W-1:0] seg_start_reg [MAX_SEGMENTS];
    logic               seg_none_reg  [MAX_SEGMENTS];
    logic [POS_W-1:0]   seg_tl_reg    [MAX_SEGMENTS];
    logic [COUNT_W-1:0] seg_len_reg   [MAX_SEGMENTS];

    logic [COUNT_W-1:0] wc_reg, seg_count_reg;
    item_t              item_reg;
    logic [SEG_CW-1:0]  k_reg, live_reg;
    logic               extend_reg;
    logic [COUNT_W-1:0] diff_reg, start_reg, pos_reg;

    // Result register
    logic [SAMPLE_W-1:0] res_ch0_reg, res_ch1_reg;
    logic                res_cov_reg, res_ovr_reg, res_open_reg;

    logic [SEG_AW-1:0]   newest_slot, scan_slot;
    logic [SAMPLE_W-1:0] wr_ch1;
    logic                contiguous, hit, q_ge;
    logic [COUNT_W-1:0]  diff;
    logic [COUNT_W:0]    tl_end;
    logic [COUNT_W-1:0]  age;

    assign newest_slot = seg_count_reg[SEG_AW-1:0] - SEG_AW'(1);
    assign scan_slot   = newest_slot - k_reg[SEG_AW-1:0];
    assign wr_ch1      = cfg.mono ? item_reg.ch0 : item_reg.ch1;

    // Contiguity of the written frame with the newest segment
    assign tl_end = {2'b00, seg_tl_reg[newest_slot]} + {1'b0, seg_len_reg[newest_slot]};
    always_comb begin
        contiguous = 1'b0;
        if (item_reg.tl_none && seg_none_reg[newest_slot]) begin
            contiguous = 1'b1;
        end else if (!item_reg.tl_none && !seg_none_reg[newest_slot]) begin
            contiguous = (tl_end == {2'b00, item_reg.tl});
        end
    end

    // Coverage test of one segment entry during the scan
    assign q_ge = (item_reg.query >= seg_tl_reg[scan_slot]);
    assign diff = {1'b0, item_reg.query} - {1'b0, seg_tl_reg[scan_slot]};
    assign hit  = !seg_none_reg[scan_slot] && q_ge && (diff < seg_len_reg[scan_slot]);
    assign age  = wc_reg - pos_reg;

    assign pop      = (state_reg == ST_IDLE) && head.valid;
    assign ring_we  = (state_reg == ST_WR_CHK);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {5'd0, res_open_reg, res_ovr_reg, res_cov_reg, res_ch1_reg, res_ch0_reg};

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    state_next = (head.item.mode == MODE_READ) ? ST_RD_SCN : ST_WR_CHK;
                end
            end
            ST_WR_CHK: state_next = ST_WR_UPD;
            ST_WR_UPD: state_next = ST_OUT;
            ST_RD_SCN: begin
                if (k_reg == live_reg) begin
                    state_next = ST_OUT;
                end else if (hit) begin
                    state_next = ST_RD_POS;
                end
            end
            ST_RD_POS: state_next = ST_RD_AGE;
            ST_RD_AGE: state_next = (age <= COUNT_W'(cfg.usable)) ? ST_RD_DAT : ST_OUT;
            ST_RD_DAT: state_next = ST_OUT;
            ST_OUT:    state_next = m_tready ? ST_IDLE : ST_OUT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wc_reg        <= '0;
            seg_count_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_WR_UPD) begin
                wc_reg <= wc_reg + COUNT_W'(1);
                if (!extend_reg) begin
                    seg_count_reg <= seg_count_reg + COUNT_W'(1);
                end
            end
        end
    end

    // Datapath registers and segment table
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                item_reg     <= head.item;
                k_reg        <= '0;
                live_reg     <= (|seg_count_reg[COUNT_W-1:SEG_AW]) ? SEG_CW'(MAX_SEGMENTS)
                                : SEG_CW'(seg_count_reg[SEG_AW-1:0]);
                res_ch0_reg  <= '0;
                res_ch1_reg  <= '0;
                res_cov_reg  <= 1'b0;
                res_ovr_reg  <= 1'b0;
                res_open_reg <= 1'b0;
            end
            ST_WR_CHK: begin
                extend_reg <= (seg_count_reg != '0) && contiguous
                              && (seg_len_reg[newest_slot] != '1);
            end
            ST_WR_UPD: begin
                res_open_reg <= !extend_reg;
                if (extend_reg) begin
                    seg_len_reg[newest_slot] <= seg_len_reg[newest_slot] + COUNT_W'(1);
                end else begin
                    seg_start_reg[seg_count_reg[SEG_AW-1:0]] <= wc_reg;
                    seg_none_reg[seg_count_reg[SEG_AW-1:0]]  <= item_reg.tl_none;
                    seg_tl_reg[seg_count_reg[SEG_AW-1:0]]    <= item_reg.tl_none ? '1 : item_reg.tl;
                    seg_len_reg[seg_count_reg[SEG_AW-1:0]]   <= COUNT_W'(1);
                end
            end
            ST_RD_SCN: begin
                k_reg     <= k_reg + SEG_CW'(1);
                diff_reg  <= diff;
                start_reg <= seg_start_reg[scan_slot];
            end
            ST_RD_POS: pos_reg <= start_reg + diff_reg;
            ST_RD_AGE: begin
                if (age > COUNT_W'(cfg.usable)) begin
                    res_ovr_reg <= 1'b1;
                end
            end
            ST_RD_DAT: begin
                res_ch0_reg <= rdata_reg[SAMPLE_W-1:0];
                res_ch1_reg <= rdata_reg[2*SAMPLE_W-1:SAMPLE_W];
                res_cov_reg <= 1'b1;
            end
            ST_OUT, ST_SPARE: begin
            end
            default: begin
            end
        endcase
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[wc_reg[RING_AW-1:0]] <= {wr_ch1, item_reg.ch0};
        end
        rdata_reg <= ring_mem[pos_reg[RING_AW-1:0]];
    end

    // A result never reports both a hit and an overrun.
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(res_cov_reg && res_ovr_reg))
        else $error("covered and overrun both set");

    // Opening a segment is reported only for writes.
    a_open_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_open_reg) |-> (item_reg.mode == MODE_WRITE))
        else $error("segment open flagged on a read");

    // The scan never walks past the live segments.
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD_SCN) |-> (k_reg <= live_reg))
        else $error("segment scan overran");

    // Each write advances the write count by exactly one.
    a_wc_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WR_UPD) |=> (wc_reg == $past(wc_reg) + COUNT_W'(1)))
        else $error("write count step wrong");

endmodule

// ===== rtl/timeline_capture_ring.sv =====
// Sequence: a write passes through check, update and output states; a read scans
// segment entries, newest first, then on a hit forms the ring position, checks its age
// and fetches the samples; on overrun it skips the fetch, and on a miss it goes to output.
// The back end takes the next queued item only once the previous result is accepted.
// Reset: counters, queue, sequencer and configuration return to reset values;
// the sample ring and segment table are not cleared and hold data only once written.
module timeline_capture_ring import tcr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: sample_ch0, sample_ch1, timeline_pos, query_pos, one pad bit
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: mode
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: out_ch0, out_ch1, covered, overrun, opened_segment, five pad bits
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [CHAN_W-1:0]  chan_reg;
    logic [GUARD_W-1:0] guard_reg;
    logic               cfg_we;
    cfg_t               cfg;
    queue_head_t        head;
    logic               pop;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg  <= INPUT_CHANNELS_RST;
            guard_reg <= GUARD_SAMPLES_RST[GUARD_W-1:0];
        end else if (cfg_we) begin
            unique case (paddr[2])
                REG_INPUT_CHANNELS: chan_reg  <= pwdata[CHAN_W-1:0];
                REG_GUARD_SAMPLES:  guard_reg <= pwdata[GUARD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_INPUT_CHANNELS: prdata = 32'(chan_reg);
            REG_GUARD_SAMPLES:  prdata = 32'(guard_reg);
            default:            prdata = '0;
        endcase
    end

    // Usable window is depth less guard; the guard never reaches the depth.
    assign cfg.mono   = (chan_reg <= CHAN_W'(1));
    assign cfg.usable = WIN_W'(RING_DEPTH) - WIN_W'(guard_reg);

    tcr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .pop      (pop)
    );

    tcr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
